>>> src/tpsc_pkg.sv
`default_nettype none

package tpsc_pkg;

	// Point geometry
	localparam int COORD_WIDTH = 24;
	localparam int NUM_SLOTS   = 10;
	localparam int SLOT_W      = 4;
	localparam int ADDR_W      = $clog2(NUM_SLOTS);
	localparam int POINT_W     = 3 * COORD_WIDTH;

	// Distance arithmetic
	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int SQ_W    = 2 * COORD_WIDTH;
	localparam int DIST_W  = 2 * COORD_WIDTH + 2;
	localparam int LO_W    = DIST_W / 2;
	localparam int HI_W    = DIST_W - LO_W;
	localparam int THR_W   = 16;
	localparam int THR_FRAC = 8;
	localparam int THR2_W  = 2 * THR_W;
	localparam int SHIFT   = 2 * THR_FRAC;
	localparam int PLO_W   = LO_W + THR2_W;
	localparam int PHI_W   = HI_W + THR2_W;
	localparam int PROD_W  = DIST_W + THR2_W;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(256);

	// Edges and tests
	localparam int NUM_EDGES = 3;
	localparam int EDGE_W    = $clog2(NUM_EDGES);
	localparam int NUM_CMP   = 12;
	localparam int CMP_W     = $clog2(NUM_CMP);

	// Program counter
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] PC_IDLE = '0;

	// Control point slots
	localparam logic [ADDR_W-1:0] S300 = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] S210 = ADDR_W'(1);
	localparam logic [ADDR_W-1:0] S201 = ADDR_W'(2);
	localparam logic [ADDR_W-1:0] S120 = ADDR_W'(3);
	localparam logic [ADDR_W-1:0] S111 = ADDR_W'(4);
	localparam logic [ADDR_W-1:0] S102 = ADDR_W'(5);
	localparam logic [ADDR_W-1:0] S030 = ADDR_W'(6);
	localparam logic [ADDR_W-1:0] S021 = ADDR_W'(7);
	localparam logic [ADDR_W-1:0] S012 = ADDR_W'(8);
	localparam logic [ADDR_W-1:0] S003 = ADDR_W'(9);

	// Edge registers: A = 300-030, B = 300-003, C = 030-003
	localparam logic [EDGE_W-1:0] EDGE_A = EDGE_W'(0);
	localparam logic [EDGE_W-1:0] EDGE_B = EDGE_W'(1);
	localparam logic [EDGE_W-1:0] EDGE_C = EDGE_W'(2);

	// Test result bits: centre tests pair up per corner, boundary tests OR together
	localparam logic [CMP_W-1:0] CC_300_A = CMP_W'(0);
	localparam logic [CMP_W-1:0] CC_300_B = CMP_W'(1);
	localparam logic [CMP_W-1:0] CC_030_C = CMP_W'(2);
	localparam logic [CMP_W-1:0] CC_030_A = CMP_W'(3);
	localparam logic [CMP_W-1:0] CC_003_C = CMP_W'(4);
	localparam logic [CMP_W-1:0] CC_003_B = CMP_W'(5);
	localparam logic [CMP_W-1:0] CB_A0    = CMP_W'(6);
	localparam logic [CMP_W-1:0] CB_A1    = CMP_W'(7);
	localparam logic [CMP_W-1:0] CB_C0    = CMP_W'(8);
	localparam logic [CMP_W-1:0] CB_C1    = CMP_W'(9);
	localparam logic [CMP_W-1:0] CB_B0    = CMP_W'(10);
	localparam logic [CMP_W-1:0] CB_B1    = CMP_W'(11);

	typedef enum logic [2:0] {
		U_NOP,
		U_EDGE,
		U_MUL,
		U_ADD,
		U_CMP,
		U_DONE
	} uop_t;

	typedef enum logic [1:0] {
		J_NEXT,
		J_IDLE,
		J_ALWAYS
	} jmp_t;

	typedef struct packed {
		uop_t              uop;
		jmp_t              jmp;
		logic [STEP_W-1:0] tgt;
		logic [ADDR_W-1:0] pa;
		logic [ADDR_W-1:0] pb;
		logic [EDGE_W-1:0] sel;
		logic [CMP_W-1:0]  cidx;
	} ucw_t;

	typedef enum logic [1:0] {
		PK_NONE,
		PK_EDGE,
		PK_CMP
	} pk_t;

	typedef struct packed {
		pk_t               pk;
		logic [EDGE_W-1:0] sel;
		logic [CMP_W-1:0]  cidx;
	} tag_t;

	function automatic ucw_t mk(input uop_t op, input jmp_t j, input logic [STEP_W-1:0] t,
			input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b,
			input logic [EDGE_W-1:0] s, input logic [CMP_W-1:0] c);
		ucw_t w;
		w.uop  = op;
		w.jmp  = j;
		w.tgt  = t;
		w.pa   = a;
		w.pb   = b;
		w.sel  = s;
		w.cidx = c;
		return w;
	endfunction

	function automatic ucw_t nop();
		return mk(U_NOP, J_NEXT, PC_IDLE, '0, '0, '0, '0);
	endfunction

	function automatic ucw_t edge_d(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b,
			input logic [EDGE_W-1:0] s);
		return mk(U_EDGE, J_NEXT, PC_IDLE, a, b, s, '0);
	endfunction

	function automatic ucw_t cmp_d(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b,
			input logic [EDGE_W-1:0] s, input logic [CMP_W-1:0] c);
		return mk(U_CMP, J_NEXT, PC_IDLE, a, b, s, c);
	endfunction

	// Microprogram. Edge distances are stored as they leave the distance pipe,
	// products by the add step after each multiply; the tests read the products at the pipe's end.
	function automatic ucw_t ucode(input logic [STEP_W-1:0] pc);
		ucw_t w;
		unique case (pc)
			0:  w = mk(U_NOP, J_IDLE, PC_IDLE, '0, '0, '0, '0);
			1:  w = edge_d(S300, S030, EDGE_A);
			2:  w = edge_d(S300, S003, EDGE_B);
			3:  w = edge_d(S030, S003, EDGE_C);
			4:  w = nop();
			5:  w = nop();
			6:  w = mk(U_MUL, J_NEXT, PC_IDLE, '0, '0, EDGE_A, '0);
			7:  w = mk(U_ADD, J_NEXT, PC_IDLE, '0, '0, EDGE_A, '0);
			8:  w = mk(U_MUL, J_NEXT, PC_IDLE, '0, '0, EDGE_B, '0);
			9:  w = mk(U_ADD, J_NEXT, PC_IDLE, '0, '0, EDGE_B, '0);
			10: w = mk(U_MUL, J_NEXT, PC_IDLE, '0, '0, EDGE_C, '0);
			11: w = mk(U_ADD, J_NEXT, PC_IDLE, '0, '0, EDGE_C, '0);
			12: w = cmp_d(S300, S111, EDGE_A, CC_300_A);
			13: w = cmp_d(S300, S111, EDGE_B, CC_300_B);
			14: w = cmp_d(S030, S111, EDGE_C, CC_030_C);
			15: w = cmp_d(S030, S111, EDGE_A, CC_030_A);
			16: w = cmp_d(S003, S111, EDGE_C, CC_003_C);
			17: w = cmp_d(S003, S111, EDGE_B, CC_003_B);
			18: w = cmp_d(S300, S120, EDGE_A, CB_A0);
			19: w = cmp_d(S030, S210, EDGE_A, CB_A1);
			20: w = cmp_d(S030, S012, EDGE_C, CB_C0);
			21: w = cmp_d(S003, S021, EDGE_C, CB_C1);
			22: w = cmp_d(S300, S102, EDGE_B, CB_B0);
			23: w = cmp_d(S003, S201, EDGE_B, CB_B1);
			24: w = nop();
			25: w = nop();
			26: w = nop();
			27: w = nop();
			28: w = mk(U_DONE, J_ALWAYS, PC_IDLE, '0, '0, '0, '0);
			default: w = mk(U_NOP, J_ALWAYS, PC_IDLE, '0, '0, '0, '0);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> src/tpsc_ram.sv
`default_nettype none

module tpsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output      logic [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output      logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

>>> src/triangle_patch_shape_check.sv
`default_nettype none

// Shape check for a cubic triangular patch.
// Input: one control point per transaction, taken at a rising edge with start
// high and busy low. point_slot picks the store entry (300,210,201,120,111,102,
// 030,021,012,003 as 0..9; 10..15 store nothing). Points load one per cycle
// while busy is low. A transaction with last_point high stores its point, then
// raises busy while a microcoded sequencer walks the evaluation: the distances
// of edges A, B and C, their threshold products, then the centre and boundary distance tests; distances
// and tests run through one four-stage squared-distance pipe fed by a
// dual-read point RAM. The result (center_bad, boundary_bad) is registered and
// shown with done high for one cycle once the sequencer reaches its final step;
// busy is low in that same cycle, so the next point may be taken then. The
// receiver has no back-pressure: a result not taken while done is high is gone.
// Config: threshold (8 fraction bits) is written on cfg_data when cfg_valid
// is high; cfg_ready is always high. Write it only while the block is idle.
// Reset clears the sequencer, the result strobe and sets threshold to 1.0.
// The point store has no reset; every slot read must be written first.
module triangle_patch_shape_check (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output      logic                                 busy,
	input  wire logic [tpsc_pkg::SLOT_W-1:0]          point_slot,
	input  wire logic signed [tpsc_pkg::COORD_WIDTH-1:0] coord_x,
	input  wire logic signed [tpsc_pkg::COORD_WIDTH-1:0] coord_y,
	input  wire logic signed [tpsc_pkg::COORD_WIDTH-1:0] coord_z,
	input  wire logic                                 last_point,
	output      logic                                 done,
	output      logic                                 center_bad,
	output      logic                                 boundary_bad,
	input  wire logic                                 cfg_valid,
	output      logic                                 cfg_ready,
	input  wire logic [tpsc_pkg::THR_W-1:0]           cfg_data
);

	localparam int CW = tpsc_pkg::COORD_WIDTH;

	// Sequencer
	logic [tpsc_pkg::STEP_W-1:0] step_q;
	tpsc_pkg::ucw_t              uc;
	logic                        accept;
	logic                        trig;
	logic                        done_q;
	logic                        center_bad_q;
	logic                        boundary_bad_q;

	// Threshold
	logic [tpsc_pkg::THR_W-1:0]  thr_q;
	logic [tpsc_pkg::THR2_W-1:0] thr2_q;

	// Point store
	logic                         ram_we;
	logic [tpsc_pkg::POINT_W-1:0] ram_wdata;
	logic [tpsc_pkg::POINT_W-1:0] pa_s1;
	logic [tpsc_pkg::POINT_W-1:0] pb_s1;

	// Distance pipe
	tpsc_pkg::tag_t              tag_c;
	tpsc_pkg::tag_t              tag_s1;
	tpsc_pkg::tag_t              tag_s2;
	tpsc_pkg::tag_t              tag_s3;
	tpsc_pkg::tag_t              tag_s4;
	logic [tpsc_pkg::DIFF_W-1:0] diff_c [3];
	logic [CW-1:0]               mag_c  [3];
	logic [CW-1:0]               mag_s2 [3];
	logic [tpsc_pkg::SQ_W-1:0]   sq_s3  [3];
	logic [tpsc_pkg::DIST_W-1:0] sum_s4;

	// Edge terms and test results
	logic [tpsc_pkg::DIST_W-1:0] dist_q [tpsc_pkg::NUM_EDGES];
	logic [tpsc_pkg::PROD_W-1:0] prod_q [tpsc_pkg::NUM_EDGES];
	logic [tpsc_pkg::PLO_W-1:0]  plo_q;
	logic [tpsc_pkg::PHI_W-1:0]  phi_q;
	logic [tpsc_pkg::DIST_W-1:0] dist_sel;
	logic [tpsc_pkg::PROD_W-1:0] lhs;
	logic [tpsc_pkg::NUM_CMP-1:0] cmp_q;
	logic                        center_c;
	logic                        boundary_c;

	assign uc        = tpsc_pkg::ucode(step_q);
	assign busy      = (step_q != tpsc_pkg::PC_IDLE);
	assign accept    = start & ~busy;
	assign trig      = accept & last_point;
	assign cfg_ready = 1'b1;

	assign done         = done_q;
	assign center_bad   = center_bad_q;
	assign boundary_bad = boundary_bad_q;

	// ---------------------------------------------------------------------
	// Threshold register; its square is kept ready for the product steps
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= tpsc_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		thr2_q <= tpsc_pkg::THR2_W'(thr_q) * tpsc_pkg::THR2_W'(thr_q);
	end

	// ---------------------------------------------------------------------
	// Point store: written by every accepted transaction with a valid slot,
	// read at two slots per step by the microprogram
	// ---------------------------------------------------------------------
	assign ram_we    = accept && (point_slot < tpsc_pkg::SLOT_W'(tpsc_pkg::NUM_SLOTS));
	assign ram_wdata = {coord_z, coord_y, coord_x};

	tpsc_ram #(
		.WIDTH (tpsc_pkg::POINT_W),
		.DEPTH (tpsc_pkg::NUM_SLOTS)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (point_slot[tpsc_pkg::ADDR_W-1:0]),
		.wdata   (ram_wdata),
		.raddr_a (uc.pa),
		.rdata_a (pa_s1),
		.raddr_b (uc.pb),
		.rdata_b (pb_s1)
	);

	// ---------------------------------------------------------------------
	// Sequencer: step counter, jumps and the registered result
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= tpsc_pkg::PC_IDLE;
			done_q         <= 1'b0;
			center_bad_q   <= 1'b0;
			boundary_bad_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (uc.jmp)
				tpsc_pkg::J_NEXT: begin
					step_q <= step_q + tpsc_pkg::STEP_W'(1);
				end
				tpsc_pkg::J_IDLE: begin
					// idle step: hold until a last point arrives
					if (trig) begin
						step_q <= step_q + tpsc_pkg::STEP_W'(1);
					end else begin
						step_q <= uc.tgt;
					end
				end
				tpsc_pkg::J_ALWAYS: begin
					step_q <= uc.tgt;
				end
				default: begin
					step_q <= tpsc_pkg::PC_IDLE;
				end
			endcase
			if (uc.uop == tpsc_pkg::U_DONE) begin
				done_q         <= 1'b1;
				center_bad_q   <= center_c;
				boundary_bad_q <= boundary_c;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Distance pipe. s1: RAM data, s2: |difference| per axis,
	// s3: squares, s4: sum; at s4 the sum is stored as an edge or tested.
	// ---------------------------------------------------------------------
	always_comb begin
		tag_c.sel  = uc.sel;
		tag_c.cidx = uc.cidx;
		unique case (uc.uop)
			tpsc_pkg::U_EDGE: tag_c.pk = tpsc_pkg::PK_EDGE;
			tpsc_pkg::U_CMP:  tag_c.pk = tpsc_pkg::PK_CMP;
			default:          tag_c.pk = tpsc_pkg::PK_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '{pk: tpsc_pkg::PK_NONE, sel: '0, cidx: '0};
			tag_s2 <= '{pk: tpsc_pkg::PK_NONE, sel: '0, cidx: '0};
			tag_s3 <= '{pk: tpsc_pkg::PK_NONE, sel: '0, cidx: '0};
			tag_s4 <= '{pk: tpsc_pkg::PK_NONE, sel: '0, cidx: '0};
		end else begin
			tag_s1 <= tag_c;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff_c[k] = {pa_s1[k*CW + CW - 1], pa_s1[k*CW +: CW]}
			          - {pb_s1[k*CW + CW - 1], pb_s1[k*CW +: CW]};
			// difference of two coords never reaches 2^CW in magnitude
			mag_c[k]  = diff_c[k][CW] ? CW'(~diff_c[k] + tpsc_pkg::DIFF_W'(1))
			                          : diff_c[k][CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			mag_s2[k] <= mag_c[k];
			sq_s3[k]  <= tpsc_pkg::SQ_W'(mag_s2[k]) * tpsc_pkg::SQ_W'(mag_s2[k]);
		end
		sum_s4 <= tpsc_pkg::DIST_W'(sq_s3[0]) + tpsc_pkg::DIST_W'(sq_s3[1])
		        + tpsc_pkg::DIST_W'(sq_s3[2]);
	end

	// ---------------------------------------------------------------------
	// Edge distances, threshold products (two half products, then a sum)
	// and the tests d^2 * 2^16 > thr^2 * D^2
	// ---------------------------------------------------------------------
	assign dist_sel = dist_q[uc.sel];
	assign lhs      = tpsc_pkg::PROD_W'({sum_s4, {tpsc_pkg::SHIFT{1'b0}}});

	always_ff @(posedge clk) begin
		if (tag_s4.pk == tpsc_pkg::PK_EDGE) begin
			dist_q[tag_s4.sel] <= sum_s4;
		end
		if (tag_s4.pk == tpsc_pkg::PK_CMP) begin
			cmp_q[tag_s4.cidx] <= (lhs > prod_q[tag_s4.sel]);
		end
		if (uc.uop == tpsc_pkg::U_MUL) begin
			plo_q <= tpsc_pkg::PLO_W'(dist_sel[tpsc_pkg::LO_W-1:0])
			       * tpsc_pkg::PLO_W'(thr2_q);
			phi_q <= tpsc_pkg::PHI_W'(dist_sel[tpsc_pkg::DIST_W-1:tpsc_pkg::LO_W])
			       * tpsc_pkg::PHI_W'(thr2_q);
		end
		if (uc.uop == tpsc_pkg::U_ADD) begin
			prod_q[uc.sel] <= {phi_q, {tpsc_pkg::LO_W{1'b0}}} + tpsc_pkg::PROD_W'(plo_q);
		end
	end

	// centre: some corner sees 111 farther than T times both of its edges
	assign center_c = (cmp_q[tpsc_pkg::CC_300_A] & cmp_q[tpsc_pkg::CC_300_B])
	                | (cmp_q[tpsc_pkg::CC_030_C] & cmp_q[tpsc_pkg::CC_030_A])
	                | (cmp_q[tpsc_pkg::CC_003_C] & cmp_q[tpsc_pkg::CC_003_B]);

	// boundary: any inner edge point too far from an end
	assign boundary_c = cmp_q[tpsc_pkg::CB_A0] | cmp_q[tpsc_pkg::CB_A1]
	                  | cmp_q[tpsc_pkg::CB_C0] | cmp_q[tpsc_pkg::CB_C1]
	                  | cmp_q[tpsc_pkg::CB_B0] | cmp_q[tpsc_pkg::CB_B1];

endmodule

`default_nettype wire
